[hdl/periodic_callback_slot_scheduler_core_assert.svh]
// Assertion macros for the periodic callback slot scheduler checker.
// Included by the checker only; needs clk_i and rst_ni in scope.
`ifndef PERIODIC_CALLBACK_SLOT_SCHEDULER_CORE_ASSERT_SVH
`define PERIODIC_CALLBACK_SLOT_SCHEDULER_CORE_ASSERT_SVH

// Property checked outside reset
`define PCSS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked at every edge, reset included
`define PCSS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[hdl/pcss_pkg.sv]
// Shared types, codes and constants of the periodic callback slot scheduler.
// No dependencies; used by every module of the block.
package pcss_pkg;

  // Table size
  localparam int unsigned SLOT_COUNT = 10;

  // Field widths on the ports
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned OWNER_W    = 8;
  localparam int unsigned IVL_W      = 16;
  localparam int unsigned FIRE_W     = 10;
  localparam int unsigned SLOT_IDX_W = 4;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned PERIOD_W   = 11;

  // Internal widths derived from the table size
  localparam int unsigned IDX_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned IDX_OUT_W = (IDX_W > SLOT_IDX_W) ? IDX_W : SLOT_IDX_W;
  localparam int unsigned MASK_W    = (SLOT_COUNT > FIRE_W) ? SLOT_COUNT : FIRE_W;

  // One tick is 50 ms; divide by multiplying with ceil(2^22 / 50)
  localparam logic [IVL_W-1:0] TICK_MS     = 16'd50;
  localparam int unsigned      RECIP_SHIFT = 22;
  localparam logic [32:0]      DIV_RECIP   = 33'd83887;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REG   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_UNREG = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_SHORT     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BADOWNER  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND  = 3'd4;

  typedef logic [IDX_W-1:0]     cell_idx_t;
  typedef logic [IDX_OUT_W-1:0] idx_t;
  typedef logic [MASK_W-1:0]    mask_t;

  // Result word as it leaves the chain
  typedef struct packed {
    mask_t               mask;
    idx_t                idx;
    logic [STATUS_W-1:0] status;
  } res_t;

  // Command word handed from cell to cell
  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [OWNER_W-1:0]  owner;
    logic [PERIOD_W-1:0] period;
    logic                done;
    res_t                res;
  } token_t;

endpackage

[hdl/pcss_cell.sv]
// One slot of the scheduler table: holds owner, period and counter of a slot
// and applies the passing command word to it. Depends on pcss_pkg.
module pcss_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pcss_pkg::cell_idx_t cell_idx_i,
  input  logic                vld_i,
  input  pcss_pkg::token_t    tok_i,
  output logic                vld_o,
  output pcss_pkg::token_t    tok_o
);

  logic                          vld_q;
  pcss_pkg::token_t              tok_q, tok_d;
  logic                          valid_q, valid_d;
  logic [pcss_pkg::OWNER_W-1:0]  owner_q, owner_d;
  logic [pcss_pkg::PERIOD_W-1:0] period_q, period_d;
  logic [pcss_pkg::PERIOD_W-1:0] count_q, count_d;

  // Apply the command word to this slot
  always_comb begin
    tok_d    = tok_i;
    valid_d  = valid_q;
    owner_d  = owner_q;
    period_d = period_q;
    count_d  = count_q;
    if (vld_i) begin
      case (tok_i.cmd)
        pcss_pkg::CMD_TICK: begin
          if (valid_q) begin
            if (count_q == period_q) begin
              tok_d.res.mask = tok_i.res.mask | (pcss_pkg::mask_t'(1) << cell_idx_i);
              count_d        = pcss_pkg::PERIOD_W'(1);
            end else begin
              count_d = count_q + pcss_pkg::PERIOD_W'(1);
            end
          end
        end
        pcss_pkg::CMD_REG: begin
          if (!tok_i.done && !valid_q) begin
            valid_d          = 1'b1;
            owner_d          = tok_i.owner;
            period_d         = tok_i.period;
            count_d          = '0;
            tok_d.done       = 1'b1;
            tok_d.res.idx    = pcss_pkg::idx_t'(cell_idx_i);
            tok_d.res.status = pcss_pkg::ST_OK;
          end
        end
        pcss_pkg::CMD_UNREG: begin
          if (!tok_i.done && valid_q && (owner_q == tok_i.owner)) begin
            valid_d          = 1'b0;
            tok_d.done       = 1'b1;
            tok_d.res.idx    = pcss_pkg::idx_t'(cell_idx_i);
            tok_d.res.status = pcss_pkg::ST_OK;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      vld_q   <= vld_i;
      valid_q <= valid_d;
    end
  end

  // Slot contents and the word handed on
  always_ff @(posedge clk_i) begin
    tok_q    <= tok_d;
    owner_q  <= owner_d;
    period_q <= period_d;
    count_q  <= count_d;
  end

  assign vld_o = vld_q;
  assign tok_o = tok_q;

endmodule

[hdl/pcss_out_buf.sv]
// Two-entry result buffer: output register plus skid entry, so a finished
// word can wait while the next command walks the chain. Depends on pcss_pkg.
module pcss_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             vld_i,
  input  pcss_pkg::res_t   res_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output pcss_pkg::res_t   res_o,
  output logic             full_o
);

  logic           out_vld_q, out_vld_d;
  logic           skid_vld_q, skid_vld_d;
  pcss_pkg::res_t out_q, out_d;
  pcss_pkg::res_t skid_q, skid_d;
  logic           out_free;

  assign out_free = !out_vld_q || out_ready_i;

  // Advance the skid entry into the output register, park new words behind it
  always_comb begin
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    skid_vld_d = skid_vld_q;
    skid_d     = skid_q;
    if (out_free) begin
      if (skid_vld_q) begin
        out_vld_d  = 1'b1;
        out_d      = skid_q;
        skid_vld_d = vld_i;
        skid_d     = res_i;
      end else begin
        out_vld_d = vld_i;
        out_d     = res_i;
      end
    end else if (vld_i) begin
      skid_vld_d = 1'b1;
      skid_d     = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_vld_q;
  assign res_o       = out_q;
  assign full_o      = skid_vld_q;

endmodule

[hdl/periodic_callback_slot_scheduler_core.sv]
// Periodic callback slot scheduler, top level.
// Uses pcss_pkg, pcss_cell and pcss_out_buf.
//
// Use: one command word per input handshake (tick, register, unregister) on
// in_valid_i / in_ready_o; one result word per command on out_valid_o /
// out_ready_i, carrying the fire mask, the slot index and a status code.
// A command is decoded into a head register (bad owner and short interval are
// settled there, the interval is divided into ticks), then walks a row of
// SLOT_COUNT slot cells, one cell per cycle; each cell holds one slot.
// An accepted word passes the head register, then the cells, then the output
// register of the result buffer before it reaches the port. One command is in
// the row at a time, so a new word is taken only after the previous one has
// walked the head register and the cell row; the input reopens in the cycle
// after the word leaves the last cell.
// Stalls: a finished word waits in the output register, and one more can
// park in a skid entry behind it; the input is held off only while both are
// full or a command is in the head register or the cell row.
// Reset: the table is empty, no result is pending and the input is ready.
module periodic_callback_slot_scheduler_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [pcss_pkg::CMD_W-1:0]          command_i,
  input  logic [pcss_pkg::OWNER_W-1:0]        owner_id_i,
  input  logic [pcss_pkg::IVL_W-1:0]          interval_ms_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [pcss_pkg::FIRE_W-1:0]         fire_mask_o,
  output logic [pcss_pkg::SLOT_IDX_W-1:0]     slot_index_o,
  output logic [pcss_pkg::STATUS_W-1:0]       status_o
);

  logic                 in_accept;
  logic                 busy_q;
  logic                 skid_full;
  logic                 hd_vld_q;
  pcss_pkg::token_t     hd_q, hd_d;
  logic [32:0]          prod;
  logic                 chain_vld [pcss_pkg::SLOT_COUNT+1];
  pcss_pkg::token_t     chain_tok [pcss_pkg::SLOT_COUNT+1];
  pcss_pkg::res_t       out_res;

  assign in_accept  = in_valid_i && in_ready_o;
  assign in_ready_o = !busy_q && !skid_full;

  // Interval in ticks: multiply by the reciprocal of 50
  assign prod = 33'(interval_ms_i) * pcss_pkg::DIV_RECIP;

  // Decode the command word, settle early rejections
  always_comb begin
    hd_d            = '0;
    hd_d.cmd        = command_i;
    hd_d.owner      = owner_id_i;
    hd_d.period     = prod[pcss_pkg::RECIP_SHIFT +: pcss_pkg::PERIOD_W];
    hd_d.done       = 1'b1;
    hd_d.res.status = pcss_pkg::ST_OK;
    case (command_i)
      pcss_pkg::CMD_REG: begin
        if (owner_id_i == '0) begin
          hd_d.res.status = pcss_pkg::ST_BADOWNER;
        end else if (interval_ms_i <= pcss_pkg::TICK_MS) begin
          hd_d.res.status = pcss_pkg::ST_SHORT;
        end else begin
          hd_d.done       = 1'b0;
          hd_d.res.status = pcss_pkg::ST_FULL;
        end
      end
      pcss_pkg::CMD_UNREG: begin
        if (owner_id_i == '0) begin
          hd_d.res.status = pcss_pkg::ST_BADOWNER;
        end else begin
          hd_d.done       = 1'b0;
          hd_d.res.status = pcss_pkg::ST_NOTFOUND;
        end
      end
      default: begin
      end
    endcase
  end

  // Track the command in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      hd_vld_q <= 1'b0;
    end else begin
      hd_vld_q <= in_accept;
      if (in_accept) begin
        busy_q <= 1'b1;
      end else if (chain_vld[pcss_pkg::SLOT_COUNT]) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      hd_q <= hd_d;
    end
  end

  assign chain_vld[0] = hd_vld_q;
  assign chain_tok[0] = hd_q;

  // Row of slot cells
  for (genvar g = 0; g < pcss_pkg::SLOT_COUNT; g++) begin : g_cell
    localparam int unsigned CellNum = g;
    pcss_pkg::cell_idx_t cell_idx;
    assign cell_idx = CellNum[pcss_pkg::IDX_W-1:0];

    pcss_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (cell_idx),
      .vld_i      (chain_vld[g]),
      .tok_i      (chain_tok[g]),
      .vld_o      (chain_vld[g+1]),
      .tok_o      (chain_tok[g+1])
    );
  end

  // Hold finished words for the receiver
  pcss_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vld_i       (chain_vld[pcss_pkg::SLOT_COUNT]),
    .res_i       (chain_tok[pcss_pkg::SLOT_COUNT].res),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .res_o       (out_res),
    .full_o      (skid_full)
  );

  assign fire_mask_o  = out_res.mask[pcss_pkg::FIRE_W-1:0];
  assign slot_index_o = out_res.idx[pcss_pkg::SLOT_IDX_W-1:0];
  assign status_o     = out_res.status;

endmodule

[hdl/pcss_checker.sv]
// Port-level checker for the periodic callback slot scheduler, bound to the
// top level. Uses pcss_pkg and the assertion macro header.
`include "periodic_callback_slot_scheduler_core_assert.svh"

module pcss_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic [pcss_pkg::FIRE_W-1:0]         fire_mask_o,
  input logic [pcss_pkg::SLOT_IDX_W-1:0]     slot_index_o,
  input logic [pcss_pkg::STATUS_W-1:0]       status_o
);

  logic fail_word;
  logic fail_clean;

  assign fail_word  = out_valid_o && (status_o != pcss_pkg::ST_OK);
  assign fail_clean = (fire_mask_o == '0) && (slot_index_o == '0);

  // A pending result word is held until taken
  `PCSS_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "result word dropped")

  // Only one command walks the table at a time
  `PCSS_ASSERT(a_one_in_flight, in_valid_i && in_ready_o |=> !in_ready_o, "second word taken early")

  // A failed command reports no slot and no fired slots
  `PCSS_ASSERT(a_fail_clean, fail_word |-> fail_clean, "failed command carries data")

  // Nothing is offered while reset is held
  `PCSS_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o, "result offered in reset")

endmodule

bind periodic_callback_slot_scheduler_core pcss_checker u_pcss_checker (.*);

[tb/slot_table_sb_pkg.sv]
`timescale 1ns / 1ps
// Scoreboard for the periodic callback slot scheduler: slot table predictor and result checker.
// Depends on pcss_pkg for widths, command codes and status codes.
package slot_table_sb_pkg;
  import pcss_pkg::*;

  // Command code with no meaning; the block must answer it with all fields zero
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // Mismatches printed in full; later ones are only counted
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [FIRE_W-1:0]     fire_mask;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic [STATUS_W-1:0]   status;
  } slot_result_t;

  class slot_table_sb;
    bit                  in_use         [SLOT_COUNT];
    logic [OWNER_W-1:0]  holder         [SLOT_COUNT];
    logic [PERIOD_W-1:0] ticks_per_fire [SLOT_COUNT];
    logic [PERIOD_W-1:0] elapsed        [SLOT_COUNT];
    slot_result_t        awaited[$];
    int unsigned         mismatches;
    int unsigned         cmd_seen    [4];
    int unsigned         status_seen [8];
    int unsigned         fires;

    function new();
      foreach (in_use[i]) begin
        in_use[i]         = 1'b0;
        holder[i]         = '0;
        ticks_per_fire[i] = '0;
        elapsed[i]        = '0;
      end
      foreach (cmd_seen[i]) cmd_seen[i] = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      mismatches = 0;
      fires      = 0;
    endfunction

    // Apply one accepted command word to the slot table and queue its answer
    function void note_command(input logic [CMD_W-1:0] cmd, input logic [OWNER_W-1:0] owner,
                               input logic [IVL_W-1:0] ivl);
      slot_result_t     r;
      bit               done;
      logic [IVL_W-1:0] quot;
      r    = '0;
      done = 1'b0;
      cmd_seen[int'(cmd)]++;
      case (cmd)
        CMD_TICK: begin
          // fire slots that reached their period, then advance every live counter
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (in_use[i]) begin
              if (elapsed[i] == ticks_per_fire[i]) begin
                if (i < FIRE_W) r.fire_mask[i] = 1'b1;
                elapsed[i] = '0;
              end
              elapsed[i] = elapsed[i] + 1'b1;
            end
          end
        end
        CMD_REG: begin
          if (owner == '0) begin
            r.status = ST_BADOWNER;
          end else if (ivl <= TICK_MS) begin
            r.status = ST_SHORT;
          end else begin
            // claim the lowest free slot
            r.status = ST_FULL;
            quot     = ivl / TICK_MS;
            for (int i = 0; i < SLOT_COUNT; i++) begin
              if (!done && !in_use[i]) begin
                in_use[i]         = 1'b1;
                holder[i]         = owner;
                ticks_per_fire[i] = quot[PERIOD_W-1:0];
                elapsed[i]        = '0;
                r.slot_index      = i[SLOT_IDX_W-1:0];
                r.status          = ST_OK;
                done              = 1'b1;
              end
            end
          end
        end
        CMD_UNREG: begin
          if (owner == '0) begin
            r.status = ST_BADOWNER;
          end else begin
            // free the lowest live slot held by this owner
            r.status = ST_NOTFOUND;
            for (int i = 0; i < SLOT_COUNT; i++) begin
              if (!done && in_use[i] && holder[i] == owner) begin
                in_use[i]    = 1'b0;
                r.slot_index = i[SLOT_IDX_W-1:0];
                r.status     = ST_OK;
                done         = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
      status_seen[int'(r.status)]++;
      fires += $countones(r.fire_mask);
      awaited.push_back(r);
    endfunction

    // Compare one result word with the oldest answer waiting
    function void check_result(input logic [FIRE_W-1:0] fire_mask,
                               input logic [SLOT_IDX_W-1:0] slot_index,
                               input logic [STATUS_W-1:0] status);
      slot_result_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: result with nothing outstanding: mask %h slot %0d status %0d",
                   $time, fire_mask, slot_index, status);
        return;
      end
      want = awaited.pop_front();
      if (want.fire_mask !== fire_mask || want.slot_index !== slot_index ||
          want.status !== status) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: mismatch: expected mask %h slot %0d status %0d, got mask %h slot %0d status %0d",
                   $time, want.fire_mask, want.slot_index, want.status,
                   fire_mask, slot_index, status);
      end
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction
  endclass

endpackage

[tb/periodic_callback_slot_scheduler_core_tb.sv]
`timescale 1ns / 1ps
// Testbench top for the periodic callback slot scheduler: drives command words, checks results.
// Depends on pcss_pkg, slot_table_sb_pkg and the scheduler RTL.
module periodic_callback_slot_scheduler_core_tb;
  import pcss_pkg::*;
  import slot_table_sb_pkg::*;

  localparam int unsigned RANDOM_WORDS = 1200;
  localparam int unsigned LATENCY      = SLOT_COUNT + 2;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b1;
  logic                  in_valid_i    = 1'b0;
  logic                  in_ready_o;
  logic [CMD_W-1:0]      command_i     = CMD_TICK;
  logic [OWNER_W-1:0]    owner_id_i    = '0;
  logic [IVL_W-1:0]      interval_ms_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i   = 1'b0;
  logic [FIRE_W-1:0]     fire_mask_o;
  logic [SLOT_IDX_W-1:0] slot_index_o;
  logic [STATUS_W-1:0]   status_o;

  slot_table_sb sb;
  bit           tx_steady = 1'b0;
  bit           rx_steady = 1'b0;
  int unsigned  rx_stall_left = 0;
  int unsigned  rx_cycle = 0;

  periodic_callback_slot_scheduler_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .owner_id_i    (owner_id_i),
    .interval_ms_i (interval_ms_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .fire_mask_o   (fire_mask_o),
    .slot_index_o  (slot_index_o),
    .status_o      (status_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Idle length: mostly short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 90) return $urandom_range(3, 8);
    return $urandom_range(20, 50);
  endfunction

  // Owner mostly from a small pool so unregister finds its slot
  function automatic logic [OWNER_W-1:0] pick_owner();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) return OWNER_W'($urandom_range(1, 12));
    if (r < 92) return '0;
    return OWNER_W'($urandom_range(1, 255));
  endfunction

  // Note accepted words and check results at every edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_command(command_i, owner_id_i, interval_ms_i);
      if (out_valid_o && out_ready_i) sb.check_result(fire_mask_o, slot_index_o, status_o);
    end
  end

  // Result side: random stalls, with stretches of steady ready
  always @(posedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 256 == 0) rx_steady = ($urandom_range(0, 3) == 0);
    if (rx_steady) begin
      out_ready_i <= 1'b1;
    end else if (rx_stall_left != 0) begin
      out_ready_i <= 1'b0;
      rx_stall_left--;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 99) < 35) rx_stall_left = idle_len();
    end
  end

  // Hold one command word on the port until it is taken
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [OWNER_W-1:0] owner,
                           input logic [IVL_W-1:0] ivl);
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    owner_id_i    <= owner;
    interval_ms_i <= ivl;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Send a word after a random idle gap on the command side
  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [OWNER_W-1:0] owner,
                       input logic [IVL_W-1:0] ivl);
    int unsigned gap;
    gap = (tx_steady || $urandom_range(0, 99) < 50) ? 0 : idle_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    send_word(cmd, owner, ivl);
  endtask

  // Drop valid and wait until every outstanding result has come back
  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Random traffic in phases that favour filling, mixing or draining the table
  task automatic play_random_commands(input int unsigned count);
    int unsigned      r;
    int unsigned      phase;
    int unsigned      reg_w;
    int unsigned      unreg_w;
    logic [CMD_W-1:0] cmd;
    logic [OWNER_W-1:0] owner;
    logic [IVL_W-1:0] ivl;
    for (int unsigned k = 0; k < count; k++) begin
      if (k % 64 == 0) tx_steady = ($urandom_range(0, 3) == 0);
      if (k != 0 && k % 300 == 0) hold_until_drained();
      phase   = (k / 150) % 3;
      reg_w   = (phase == 0) ? 35 : (phase == 1) ? 20 : 10;
      unreg_w = (phase == 0) ? 10 : (phase == 1) ? 20 : 35;
      owner   = OWNER_W'($urandom_range(0, 255));
      ivl     = IVL_W'($urandom_range(0, 65535));
      r       = $urandom_range(0, 99);
      if (r < 4) begin
        cmd = CMD_UNUSED;
      end else if (r < 4 + reg_w) begin
        cmd   = CMD_REG;
        owner = pick_owner();
        r     = $urandom_range(0, 99);
        if (r < 60) ivl = IVL_W'($urandom_range(51, 600));
        else if (r < 75) ivl = IVL_W'($urandom_range(601, 3000));
        else if (r < 85) ivl = IVL_W'($urandom_range(0, 50));
        else if (r < 92) begin
          case ($urandom_range(0, 4))
            0: ivl = 16'd50;
            1: ivl = 16'd51;
            2: ivl = 16'd99;
            3: ivl = 16'd100;
            default: ivl = 16'd101;
          endcase
        end
      end else if (r < 4 + reg_w + unreg_w) begin
        cmd   = CMD_UNREG;
        owner = pick_owner();
      end else begin
        cmd = CMD_TICK;
      end
      issue(cmd, owner, ivl);
    end
  endtask

  initial begin
    sb = new();
    rst_ni <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, rejections, fill to full, firing, free and reuse
    issue(CMD_TICK,   8'd0,   16'd0);
    issue(CMD_REG,    8'd0,   16'd1000);
    issue(CMD_REG,    8'd5,   16'd50);
    issue(CMD_REG,    8'd5,   16'd0);
    issue(CMD_UNREG,  8'd0,   16'd0);
    issue(CMD_UNREG,  8'd9,   16'd0);
    issue(CMD_REG,    8'd1,   16'd51);
    issue(CMD_REG,    8'd255, 16'd65535);
    issue(CMD_REG,    8'd1,   16'd100);
    for (int unsigned o = 2; o <= 8; o++) issue(CMD_REG, OWNER_W'(o), IVL_W'(100 + 50 * o));
    issue(CMD_REG,    8'd9,   16'd200);
    issue(CMD_TICK,   8'd0,   16'd0);
    issue(CMD_TICK,   8'hFF,  16'hFFFF);
    issue(CMD_TICK,   8'd0,   16'd0);
    issue(CMD_UNREG,  8'd1,   16'd0);
    issue(CMD_UNUSED, 8'hAA,  16'hFFFF);
    issue(CMD_REG,    8'd10,  16'd99);
    issue(CMD_TICK,   8'd0,   16'd0);
    issue(CMD_UNREG,  8'd255, 16'd0);

    // Let the sender sit until the row and the output side are empty
    hold_until_drained();
    play_random_commands(RANDOM_WORDS);

    hold_until_drained();
    repeat (2 * LATENCY) @(posedge clk_i);

    $display("Run covered %0d words: %0d ticks, %0d registers, %0d unregisters, %0d unused; %0d firings.",
             sb.cmd_seen[0] + sb.cmd_seen[1] + sb.cmd_seen[2] + sb.cmd_seen[3],
             sb.cmd_seen[CMD_TICK], sb.cmd_seen[CMD_REG], sb.cmd_seen[CMD_UNREG],
             sb.cmd_seen[CMD_UNUSED], sb.fires);
    $display("Statuses: ok %0d, table full %0d, short interval %0d, bad owner %0d, not found %0d.",
             sb.status_seen[ST_OK], sb.status_seen[ST_FULL], sb.status_seen[ST_SHORT],
             sb.status_seen[ST_BADOWNER], sb.status_seen[ST_NOTFOUND]);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("Timed out with %0d results outstanding", sb.pending());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/pcss_pkg.sv
hdl/pcss_cell.sv
hdl/pcss_out_buf.sv
hdl/periodic_callback_slot_scheduler_core.sv
hdl/pcss_checker.sv
tb/slot_table_sb_pkg.sv
tb/periodic_callback_slot_scheduler_core_tb.sv
